@@ src/kms_pkg.sv @@
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, constants and the key lookup ROM of the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int SENSE_BITS = 5;
  localparam int ROM_SIZE   = 30;
  localparam int ROM_IDX_W  = 6;
  localparam int POS_W      = 3;

  localparam logic ACT_IRQ  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [7:0] KEY_LSHIFT     = 8'h2a;
  localparam logic [7:0] KEY_RSHIFT     = 8'h36;
  localparam logic [7:0] KEY_EXT_MIN    = 8'h48;
  localparam logic [7:0] CODE_EXT       = 8'he0;
  localparam logic [7:0] CODE_LSHIFT_B  = 8'h09;
  localparam logic [7:0] CODE_RSHIFT_B  = 8'h04;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd25;

  // one press sequence: two words (a down, a up) or four (a down, b down, a up, b up)
  typedef struct packed {
    logic       four;
    logic [7:0] code_a;
    logic [7:0] code_b;
  } seq_t;

  function automatic logic [7:0] key_rom(input logic [ROM_IDX_W-1:0] idx);
    logic [7:0] k;
    case (idx)
      6'd0:    k = 8'h0e;
      6'd1:    k = 8'h0c;
      6'd3:    k = 8'h48;
      6'd6:    k = 8'h02;
      6'd7:    k = 8'h03;
      6'd8:    k = 8'h2a;
      6'd9:    k = 8'h04;
      6'd12:   k = 8'h08;
      6'd13:   k = 8'h09;
      6'd14:   k = 8'h0b;
      6'd15:   k = 8'h0a;
      6'd18:   k = 8'h05;
      6'd19:   k = 8'h06;
      6'd20:   k = 8'h36;
      6'd21:   k = 8'h07;
      6'd24:   k = 8'h4b;
      6'd25:   k = 8'h4d;
      6'd27:   k = 8'h50;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

@@ src/kms_decode.sv @@
// ----------------------------------------------------------------------------
// kms_decode
// Finds the pressed row and column in one matrix scan and looks up the key.
// ----------------------------------------------------------------------------
module kms_decode #(
  parameter int ROWS = 5,
  parameter int COLS = 6
) (
  input  logic [kms_pkg::SENSE_BITS-1:0]      idle_rows,
  input  logic [kms_pkg::SENSE_BITS*COLS-1:0] scan_rows,
  output logic                                key_valid,
  output logic [7:0]                          key
);

  localparam int RUSE = (ROWS < kms_pkg::SENSE_BITS) ? ROWS : kms_pkg::SENSE_BITS;

  logic [kms_pkg::POS_W-1:0]     row;
  logic [kms_pkg::POS_W-1:0]     col;
  logic [kms_pkg::ROM_IDX_W-1:0] idx;

  always_comb begin
    row       = '0;
    col       = '0;
    key_valid = 1'b0;
    // highest active row wins
    for (int r = 0; r < RUSE; r++) begin
      if (!idle_rows[r]) begin
        row = kms_pkg::POS_W'(r);
      end
    end
    // highest column whose reading moved away from the idle sense
    for (int c = 0; c < COLS; c++) begin
      if (scan_rows[c*kms_pkg::SENSE_BITS +: kms_pkg::SENSE_BITS] != idle_rows) begin
        col       = kms_pkg::POS_W'(c);
        key_valid = 1'b1;
      end
    end
    idx = kms_pkg::ROM_IDX_W'(row) * kms_pkg::ROM_IDX_W'(COLS) + kms_pkg::ROM_IDX_W'(col);
    key = key_valid ? kms_pkg::key_rom(idx) : 8'h00;
  end

endmodule

@@ src/kms_seq.sv @@
// ----------------------------------------------------------------------------
// kms_seq
// Result register: holds a press sequence, one word out a cycle unless stalled.
// ----------------------------------------------------------------------------
module kms_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  kms_pkg::seq_t seq_in,
  output logic          free,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,   // [7:0] scancode, [8] pressed, zero fill
  output logic          out_tlast    // last
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       four_r;
  logic [7:0] code_a_r;
  logic [7:0] code_b_r;
  logic       fire;
  logic       is_last;
  logic [7:0] scancode;
  logic       pressed;

  assign fire    = valid_r && out_tready;
  assign is_last = four_r ? (idx_r == 2'd3) : (idx_r == 2'd1);
  assign free    = !valid_r || (fire && is_last);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (fire) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      four_r   <= seq_in.four;
      code_a_r <= seq_in.code_a;
      code_b_r <= seq_in.code_b;
    end
  end

  // odd words of a four-word run carry the second code; first half is key down
  assign scancode = (four_r && idx_r[0]) ? code_b_r : code_a_r;
  assign pressed  = four_r ? !idx_r[1] : !idx_r[0];

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'b0, pressed, scancode};
  assign out_tlast  = is_last;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("sequence loaded over an unfinished one");

  a_drop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last && !load) |=> !out_tvalid)
    else $error("output still valid after final word");

  a_two_word_index: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !four_r) |-> !idx_r[1])
    else $error("two-word sequence index out of range");
`endif

endmodule

@@ src/keypad_matrix_scan_to_scancodes_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_scan_to_scancodes_unit
// Matrix keypad scanner: decodes scans into scancode words with debounce.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one event per word: in_tuser 0 is a key interrupt, 1 a timer
//   tick; in_tdata holds the idle row sense and the row sense under each
//   column drive. out_* carries scancode words, in_tlast-free, out_tlast marks
//   the final word of a press sequence. cfg_wr_en/cfg_wr_data load the
//   debounce tick count; the user must write it only while the block is
//   idle, which the block itself does not enforce. An accepted word is
//   registered in the input register and decoded there; once the result
//   register is free its scancodes are loaded into it and handed out on
//   out_* one word a cycle while out_tready is high. An item gives no
//   words, two for a plain key or four for a shift or extended key; the
//   next item waits in the input register.
//   Reset (rst_n low, synchronous) empties both registers, unmasks
//   interrupts, stops the countdown and sets the debounce count to 25.
//   When out_tready is low the current word holds, one more input word is
//   taken into the input register and in_tready then drops.
// ----------------------------------------------------------------------------
module keypad_matrix_scan_to_scancodes_unit #(
  parameter int ROWS = 5,
  parameter int COLS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [4:0] idle_rows, then scan_rows, zero fill
  input  logic [((kms_pkg::SENSE_BITS * (COLS + 1) + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                in_tuser,   // action
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [7:0] scancode, [8] pressed, zero fill
  output logic                out_tlast,  // last
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  localparam int SCAN_W = kms_pkg::SENSE_BITS * COLS;

  // input register
  logic                            in_valid_r;
  logic                            in_action_r;
  logic [kms_pkg::SENSE_BITS-1:0]  in_idle_r;
  logic [SCAN_W-1:0]               in_scan_r;

  // scanner state
  logic [7:0] debounce_r;
  logic [7:0] held_key_r, held_key_nxt;
  logic [7:0] countdown_r, countdown_nxt;
  logic       running_r, running_nxt;
  logic       masked_r, masked_nxt;

  logic          key_valid;
  logic [7:0]    key;
  logic          seq_free;
  logic          advance;
  logic          load;
  logic [7:0]    start_val;
  kms_pkg::seq_t seq;

  assign advance   = in_valid_r && seq_free;
  assign in_tready = !in_valid_r || seq_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= in_tuser;
      in_idle_r   <= in_tdata[kms_pkg::SENSE_BITS-1:0];
      in_scan_r   <= in_tdata[kms_pkg::SENSE_BITS +: SCAN_W];
    end
  end

  kms_decode #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_decode (
    .idle_rows (in_idle_r),
    .scan_rows (in_scan_r),
    .key_valid (key_valid),
    .key       (key)
  );

  assign start_val = (debounce_r == 8'd0) ? 8'd1 : debounce_r;

  always_comb begin
    held_key_nxt  = held_key_r;
    countdown_nxt = countdown_r;
    running_nxt   = running_r;
    masked_nxt    = masked_r;
    load          = 1'b0;
    seq.four      = 1'b0;
    seq.code_a    = key;
    seq.code_b    = key;
    if (key == kms_pkg::KEY_LSHIFT) begin
      seq.four   = 1'b1;
      seq.code_b = kms_pkg::CODE_LSHIFT_B;
    end else if (key == kms_pkg::KEY_RSHIFT) begin
      seq.four   = 1'b1;
      seq.code_b = kms_pkg::CODE_RSHIFT_B;
    end else if (key >= kms_pkg::KEY_EXT_MIN) begin
      seq.four   = 1'b1;
      seq.code_a = kms_pkg::CODE_EXT;
    end
    if (advance) begin
      if (in_action_r == kms_pkg::ACT_IRQ) begin
        if (!masked_r) begin
          masked_nxt    = 1'b1;
          running_nxt   = 1'b1;
          countdown_nxt = start_val;
          if (key_valid) begin
            held_key_nxt = key;
            load         = 1'b1;
          end
        end
      end else if (running_r) begin
        if (countdown_r > 8'd1) begin
          countdown_nxt = countdown_r - 8'd1;
        end else if (key_valid && key == held_key_r) begin
          // key still held: rearm the debounce
          countdown_nxt = start_val;
        end else begin
          countdown_nxt = 8'd0;
          running_nxt   = 1'b0;
          masked_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= kms_pkg::DEBOUNCE_RESET;
      held_key_r  <= 8'd0;
      countdown_r <= 8'd0;
      running_r   <= 1'b0;
      masked_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        debounce_r <= cfg_wr_data;
      end
      held_key_r  <= held_key_nxt;
      countdown_r <= countdown_nxt;
      running_r   <= running_nxt;
      masked_r    <= masked_nxt;
    end
  end

  kms_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .seq_in     (seq),
    .free       (seq_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_mask_tracks_timer: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == masked_r)
    else $error("interrupt mask and debounce timer out of step");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (countdown_r != 8'd0))
    else $error("debounce running with empty countdown");

  a_tick_no_words: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_action_r == kms_pkg::ACT_TICK) |-> !load)
    else $error("timer tick produced scancodes");
`endif

endmodule
